// ===== rtl/complex_power_core_assert.svh =====
// assertion macros for the complex power core
// no dependencies; expects clk and rst_n in the including scope
`ifndef COMPLEX_POWER_CORE_ASSERT_SVH
`define COMPLEX_POWER_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define CPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define CPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cpc_pkg.sv =====
// shared types and constants for the complex power core
// no dependencies
`default_nettype none

package cpc_pkg;

    localparam int DW = 32;

    // operands for the shared complex multiplier: (ar + j*ai) * (br + j*bi)
    typedef struct packed {
        logic signed [DW-1:0] ar;
        logic signed [DW-1:0] ai;
        logic signed [DW-1:0] br;
        logic signed [DW-1:0] bi;
    } cpc_cop_t;

    // rounded and saturated product components
    typedef struct packed {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        logic                 sat;
    } cpc_cres_t;

endpackage

`default_nettype wire

// ===== rtl/cpc_cmul.sv =====
// shared complex multiplier: four registered 32x32 products, then floor shift and saturate
// depends on cpc_pkg
`default_nettype none

module cpc_cmul
    import cpc_pkg::*;
#(
    parameter int FRAC_BITS = 24
) (
    input  wire logic      clk,
    input  wire cpc_cop_t  op,
    output cpc_cres_t      res
);

    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    logic signed [DW-1:0] a_r, a_i, b_r, b_i;
    logic signed [PW-1:0] pp_rr_reg, pp_ii_reg, pp_ri_reg, pp_ir_reg;
    logic signed [SW-1:0] re_sum, im_sum, re_sh, im_sh;
    logic                 re_ovf, im_ovf;

    assign a_r = op.ar;
    assign a_i = op.ai;
    assign b_r = op.br;
    assign b_i = op.bi;

    always_ff @(posedge clk)
    begin
        pp_rr_reg <= PW'(a_r) * PW'(b_r);
        pp_ii_reg <= PW'(a_i) * PW'(b_i);
        pp_ri_reg <= PW'(a_r) * PW'(b_i);
        pp_ir_reg <= PW'(a_i) * PW'(b_r);
    end

    // exact sum at full width, then floor shift
    assign re_sum = SW'(pp_rr_reg) - SW'(pp_ii_reg);
    assign im_sum = SW'(pp_ri_reg) + SW'(pp_ir_reg);
    assign re_sh  = re_sum >>> FRAC_BITS;
    assign im_sh  = im_sum >>> FRAC_BITS;

    // out of range when the bits from the top down to the result sign disagree
    assign re_ovf = !((&re_sh[SW-1:DW-1]) || !(|re_sh[SW-1:DW-1]));
    assign im_ovf = !((&im_sh[SW-1:DW-1]) || !(|im_sh[SW-1:DW-1]));

    always_comb
    begin
        if (re_ovf)
            res.re = re_sh[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        else
            res.re = re_sh[DW-1:0];
        if (im_ovf)
            res.im = im_sh[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        else
            res.im = im_sh[DW-1:0];
        res.sat = re_ovf || im_ovf;
    end

endmodule

`default_nettype wire

// ===== rtl/complex_power_core.sv =====
// each item runs N complex products, N = squarings plus multiplies
// (N = 0 for exponent 0 or 1, at most 2*(EXP_BITS-1)); each complex product goes through the
// one shared complex multiplier in order: issue into the product register, then round and capture
// one item at a time: busy stays high until the result, start is taken in the done cycle
// done strobes for one cycle and the receiver cannot stall; reset clears state and strobe
`default_nettype none

module complex_power_core
    import cpc_pkg::*;
#(
    parameter int EXP_BITS  = 8,
    parameter int FRAC_BITS = 24
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic signed [DW-1:0] z_real,
    input  wire logic signed [DW-1:0] z_imag,
    input  wire logic [EXP_BITS-1:0]  exponent,
    output logic                      done,
    output logic signed [DW-1:0]      p_real,
    output logic signed [DW-1:0]      p_imag,
    output logic                      overflow
);

`include "complex_power_core_assert.svh"

    localparam int KW = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
    localparam logic signed [DW-1:0] ONE = DW'(1) << FRAC_BITS;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SQ_ISS  = 3'd1;
    localparam logic [2:0] ST_SQ_CAP  = 3'd2;
    localparam logic [2:0] ST_MUL_ISS = 3'd3;
    localparam logic [2:0] ST_MUL_CAP = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [KW-1:0]        k_reg, k_next;
    logic [KW-1:0]        top_bit;
    logic [EXP_BITS-1:0]  e_reg, e_next;
    logic signed [DW-1:0] zr_reg, zr_next, zi_reg, zi_next;
    logic signed [DW-1:0] pr_reg, pr_next, pi_reg, pi_next;
    logic                 ovf_reg, ovf_next;
    logic                 done_reg, done_next;
    cpc_cop_t             mul_op;
    cpc_cres_t            mul_res;

    cpc_cmul #(
        .FRAC_BITS(FRAC_BITS)
    ) u_cmul (
        .clk(clk),
        .op (mul_op),
        .res(mul_res)
    );

    // leading one of the exponent
    always_comb
    begin
        top_bit = '0;
        for (int i = 0; i < EXP_BITS; i++)
        begin
            if (exponent[i])
                top_bit = KW'(i);
        end
    end

    // squaring uses p*p, the multiply step z*p
    always_comb
    begin
        mul_op.ar = (state_reg == ST_MUL_ISS) ? zr_reg : pr_reg;
        mul_op.ai = (state_reg == ST_MUL_ISS) ? zi_reg : pi_reg;
        mul_op.br = pr_reg;
        mul_op.bi = pi_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        e_next     = e_reg;
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        pr_next    = pr_reg;
        pi_next    = pi_reg;
        ovf_next   = ovf_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    e_next   = exponent;
                    zr_next  = z_real;
                    zi_next  = z_imag;
                    ovf_next = 1'b0;
                    k_next   = top_bit - KW'(1);
                    if (exponent == '0)
                    begin
                        pr_next   = ONE;
                        pi_next   = '0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        pr_next = z_real;
                        pi_next = z_imag;
                        if (top_bit == '0)
                            done_next = 1'b1;
                        else
                            state_next = ST_SQ_ISS;
                    end
                end
            end
            ST_SQ_ISS:
            begin
                state_next = ST_SQ_CAP;
            end
            ST_SQ_CAP:
            begin
                pr_next  = mul_res.re;
                pi_next  = mul_res.im;
                ovf_next = ovf_reg || mul_res.sat;
                if (e_reg[k_reg])
                    state_next = ST_MUL_ISS;
                else if (k_reg == '0)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    k_next     = k_reg - KW'(1);
                    state_next = ST_SQ_ISS;
                end
            end
            ST_MUL_ISS:
            begin
                state_next = ST_MUL_CAP;
            end
            ST_MUL_CAP:
            begin
                pr_next  = mul_res.re;
                pi_next  = mul_res.im;
                ovf_next = ovf_reg || mul_res.sat;
                if (k_reg == '0)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    k_next     = k_reg - KW'(1);
                    state_next = ST_SQ_ISS;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        e_reg   <= e_next;
        zr_reg  <= zr_next;
        zi_reg  <= zi_next;
        pr_reg  <= pr_next;
        pi_reg  <= pi_next;
        ovf_reg <= ovf_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign p_real   = pr_reg;
    assign p_imag   = pi_reg;
    assign overflow = ovf_reg;

    `CPC_ASSERT_NOW(a_done_idle, done_reg, state_reg == ST_IDLE, "done while sequencer active")
    `CPC_ASSERT_NEXT(a_start_moves, start && !busy, busy || done_reg, "accepted start ignored")
    `CPC_ASSERT_NOW(a_cap_after_iss, (state_reg == ST_SQ_CAP) || (state_reg == ST_MUL_CAP),
        ($past(state_reg) == ST_SQ_ISS) || ($past(state_reg) == ST_MUL_ISS),
        "capture without product issue")

endmodule

`default_nettype wire
